>>> rtl/sprite_screen_rect_transform_defines.svh
// Assertion macros shared by the sprite rectangle transform RTL
`ifndef SPRITE_SCREEN_RECT_TRANSFORM_DEFINES_SVH
`define SPRITE_SCREEN_RECT_TRANSFORM_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define SSRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define SSRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ssrt_pkg.sv
// Types, constants and helper functions of the sprite rectangle transform
`timescale 1ns / 1ps
package ssrt_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_W         = 16;
    localparam int PHASE_DROP      = PHASE_W - SINE_TABLE_BITS;
    localparam logic [PHASE_W-1:0] PHASE_MASK =
        ~((PHASE_W'(1) << PHASE_DROP) - PHASE_W'(1));

    localparam logic [31:0] SIN_C1  = 32'd1686629713;
    localparam logic [31:0] SIN_C3  = 32'd693598669;
    localparam logic [31:0] SIN_C5  = 32'd85569306;
    localparam logic [31:0] SIN_C7  = 32'd5026995;
    localparam logic [31:0] SIN_C9  = 32'd172272;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int SIN_LAT   = 7;
    localparam int ROT_LAT   = 2;
    localparam int PROJ_LAT  = 3;
    localparam int DIV_STEPS = 17;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int PIPE_LAT  = 1 + SIN_LAT + ROT_LAT + PROJ_LAT + DIV_LAT;

    localparam int SIZE_W = 28;
    localparam int XW     = 35;
    localparam int NW     = 39;
    localparam int MAG_W  = 54;
    localparam int DIV_W  = 25;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_ANGLE  = 3'd6;

    typedef struct packed {
        logic        [13:0] win_w;
        logic        [13:0] win_h;
        logic        [15:0] view_w;
        logic        [15:0] view_h;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [15:0] cam_ang;
    } cfg_t;

    typedef struct packed {
        logic        [SIZE_W-1:0] sw;
        logic        [SIZE_W-1:0] sh;
        logic                     parented;
        logic signed [31:0]       px;
        logic signed [31:0]       py;
        logic signed [31:0]       parx;
        logic signed [31:0]       pary;
    } geom_t;

    typedef struct packed {
        logic        [11:0] w;
        logic        [11:0] h;
        logic signed [15:0] deg;
        logic        [1:0]  flip;
    } side_t;

    function automatic logic [15:0] view_eff(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // quarter-wave argument in Q1.30, folded on odd quadrants
    function automatic logic [30:0] phase_u(logic [PHASE_W-1:0] ph);
        logic [14:0] u14;
        u14 = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
        return {u14, 16'd0};
    endfunction

    function automatic logic [15:0] sat_q_signed(logic [DIV_STEPS-1:0] q, logic ovf,
                                                 logic neg);
        logic [DIV_STEPS-1:0] nq;
        nq = DIV_STEPS'(0) - q;
        if (neg) begin
            return (ovf || q > DIV_STEPS'(32768)) ? 16'h8000 : nq[15:0];
        end
        return (ovf || q > DIV_STEPS'(32767)) ? 16'h7FFF : q[15:0];
    endfunction

    function automatic logic [14:0] sat_q_size(logic [DIV_STEPS-1:0] q, logic ovf);
        return (ovf || q > DIV_STEPS'(32767)) ? 15'h7FFF : q[14:0];
    endfunction

    function automatic logic [15:0] sat16(logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'h7FFF;
        end
        if (v < -24'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage

>>> rtl/ssrt_sine.sv
// Pipelined sine and cosine of the parent angle, odd polynomial in Q1.30
`timescale 1ns / 1ps
module ssrt_sine (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);
    import ssrt_pkg::*;

    logic [PHASE_W-1:0] ph_s;
    logic [PHASE_W-1:0] ph_c;
    logic signed [31:0] res [2];

    assign ph_s  = {angle[12:0], 3'b000} & PHASE_MASK;
    assign ph_c  = ph_s + PHASE_W'(16384);
    assign sin_q = res[0];
    assign cos_q = res[1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [PHASE_W-1:0] ph;
        logic [30:0]        u_reg  [6];
        logic               n_reg  [6];
        logic [31:0]        u2_reg [1:4];
        logic [31:0]        t_reg  [2:5];
        logic [61:0]        sq_next;
        logic [63:0]        p_next [2:5];
        logic [63:0]        pf_next;
        logic [33:0]        v34;
        logic [30:0]        vcl;
        logic signed [31:0] res_reg;

        assign ph        = (l == 0) ? ph_s : ph_c;
        assign sq_next   = 62'(u_reg[0]) * 62'(u_reg[0]);
        assign p_next[2] = 64'(SIN_C9) * 64'(u2_reg[1]);
        assign p_next[3] = 64'(t_reg[2]) * 64'(u2_reg[2]);
        assign p_next[4] = 64'(t_reg[3]) * 64'(u2_reg[3]);
        assign p_next[5] = 64'(t_reg[4]) * 64'(u2_reg[4]);
        assign pf_next   = 64'(t_reg[5]) * 64'(u_reg[5]);
        assign v34       = pf_next[63:30];
        assign vcl       = (v34 > 34'(Q30_ONE)) ? Q30_ONE : v34[30:0];
        assign res[l]    = res_reg;

        always_ff @(posedge aclk) begin
            if (en) begin
                u_reg[0] <= phase_u(ph);
                n_reg[0] <= ph[15];
                for (int k = 1; k < 6; k++) begin
                    u_reg[k] <= u_reg[k-1];
                    n_reg[k] <= n_reg[k-1];
                end
                u2_reg[1] <= sq_next[61:30];
                for (int k = 2; k < 5; k++) begin
                    u2_reg[k] <= u2_reg[k-1];
                end
                t_reg[2] <= SIN_C7 - p_next[2][61:30];
                t_reg[3] <= SIN_C5 - p_next[3][61:30];
                t_reg[4] <= SIN_C3 - p_next[4][61:30];
                t_reg[5] <= SIN_C1 - p_next[5][61:30];
                res_reg  <= n_reg[5] ? -$signed({1'b0, vcl}) : $signed({1'b0, vcl});
            end
        end
    end

endmodule

>>> rtl/ssrt_rot.sv
// Parent rotation and offset of the sprite position
`timescale 1ns / 1ps
module ssrt_rot (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [31:0]   sin_q,
    input  logic signed [31:0]   cos_q,
    input  ssrt_pkg::geom_t      geom,
    output logic signed [ssrt_pkg::XW-1:0] x,
    output logic signed [ssrt_pkg::XW-1:0] y
);
    import ssrt_pkg::*;

    logic signed [63:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    geom_t              g_reg;
    logic signed [63:0] sx_next, sy_next;
    logic signed [XW-1:0] x_next, y_next, x_reg, y_reg;

    assign sx_next = pxc_reg - pys_reg;
    assign sy_next = pxs_reg + pyc_reg;

    always_comb begin
        if (g_reg.parented) begin
            x_next = XW'(g_reg.parx) + $signed({sx_next[63], sx_next[63:30]});
            y_next = XW'(g_reg.pary) + $signed({sy_next[63], sy_next[63:30]});
        end else begin
            x_next = XW'(g_reg.px);
            y_next = XW'(g_reg.py);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pxc_reg <= 64'(geom.px) * 64'(cos_q);
            pys_reg <= 64'(geom.py) * 64'(sin_q);
            pxs_reg <= 64'(geom.px) * 64'(sin_q);
            pyc_reg <= 64'(geom.py) * 64'(cos_q);
            g_reg   <= geom;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

>>> rtl/ssrt_proj.sv
// Camera projection numerators scaled by the window size, as sign and magnitude
`timescale 1ns / 1ps
module ssrt_proj (
    input  logic                             aclk,
    input  logic                             en,
    input  ssrt_pkg::cfg_t                   cfg,
    input  logic signed [ssrt_pkg::XW-1:0]   x,
    input  logic signed [ssrt_pkg::XW-1:0]   y,
    input  logic [ssrt_pkg::SIZE_W-1:0]      sw,
    input  logic [ssrt_pkg::SIZE_W-1:0]      sh,
    output logic [3:0][ssrt_pkg::MAG_W-1:0]  mag,
    output logic [3:0]                       neg
);
    import ssrt_pkg::*;

    logic [15:0]             vw, vh;
    logic signed [NW-1:0]    nx_next, ny_next, nx_reg, ny_reg;
    logic [SIZE_W-1:0]       sw_reg, sh_reg;
    logic signed [MAG_W-1:0] px_reg, py_reg;
    logic [42:0]             zw_reg, zh_reg;
    logic [3:0][MAG_W-1:0]   mag_reg;
    logic [3:0]              neg_reg;

    assign vw = view_eff(cfg.view_w);
    assign vh = view_eff(cfg.view_h);

    assign nx_next = ((NW'(x) - NW'(cfg.cam_x)) <<< 1) - $signed({11'd0, sw})
                     + $signed({15'd0, vw, 8'd0});
    assign ny_next = ((NW'(cfg.cam_y) - NW'(y)) <<< 1) - $signed({11'd0, sh})
                     + $signed({15'd0, vh, 8'd0});

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            sw_reg     <= sw;
            sh_reg     <= sh;
            px_reg     <= MAG_W'(nx_reg) * $signed({40'd0, cfg.win_w});
            py_reg     <= MAG_W'(ny_reg) * $signed({40'd0, cfg.win_h});
            zw_reg     <= 43'({sw_reg, 1'b0}) * 43'(cfg.win_w);
            zh_reg     <= 43'({sh_reg, 1'b0}) * 43'(cfg.win_h);
            mag_reg[0] <= px_reg[MAG_W-1] ? (~px_reg + MAG_W'(1)) : px_reg;
            mag_reg[1] <= py_reg[MAG_W-1] ? (~py_reg + MAG_W'(1)) : py_reg;
            mag_reg[2] <= MAG_W'(zw_reg);
            mag_reg[3] <= MAG_W'(zh_reg);
            neg_reg    <= {2'b00, py_reg[MAG_W-1], px_reg[MAG_W-1]};
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

>>> rtl/ssrt_div.sv
// Pipelined restoring divider by 512 times the viewport size, one quotient bit a stage
`timescale 1ns / 1ps
module ssrt_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [ssrt_pkg::MAG_W-1:0]        mag,
    input  logic                              neg,
    input  logic [ssrt_pkg::DIV_W-1:0]        d,
    output logic [ssrt_pkg::DIV_STEPS-1:0]    q,
    output logic                              ovf,
    output logic                              neg_out
);
    import ssrt_pkg::*;

    logic [MAG_W-1:0]     d_ext;
    logic [MAG_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [1:DIV_STEPS];
    logic                 ovf_reg [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];

    assign d_ext = {{(MAG_W-DIV_W){1'b0}}, d};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= mag;
            ovf_reg[0] <= (mag >= (d_ext << DIV_STEPS));
            neg_reg[0] <= neg;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
        localparam int B = DIV_STEPS - i;
        logic [MAG_W-1:0] dsh;
        logic             ge;

        assign dsh = d_ext << B;
        assign ge  = (rem_reg[i-1] >= dsh);

        if (i == 1) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[i] <= {{(DIV_STEPS-1){1'b0}}, ge};
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[i] <= {q_reg[i-1][DIV_STEPS-2:0], ge};
                end
            end
        end

        if (i < DIV_STEPS) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= ge ? (rem_reg[i-1] - dsh) : rem_reg[i-1];
                end
            end
        end
    end

    assign q       = q_reg[DIV_STEPS];
    assign ovf     = ovf_reg[DIV_STEPS];
    assign neg_out = neg_reg[DIV_STEPS];

endmodule

>>> rtl/sprite_screen_rect_transform.sv
// Top level: sprite world-to-window rectangle transform pipeline
//
//  port group  | dir | payload
//  s_*         | in  | sprite word, tuser = has_parent
//  m_*         | out | window rectangle word
//  cfg_*       | in  | register write, no read-back
//
// One word per cycle while m_tready does not stall; the path from input accept to output valid
// runs through the input register, the sine polynomial (7), rotation (2), projection (3), the
// 18-stage divider and the output register.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall at m_tready freezes every stage at once; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "sprite_screen_rect_transform_defines.svh"
module sprite_screen_rect_transform (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sprite_width, sprite_height, scale_x, scale_y, pos_x, pos_y, sprite_angle,
    // parent_x, parent_y, parent_angle, flip_in, zero pad
    input  logic [223:0]                       s_tdata,
    // has_parent
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rect_x, rect_y, rect_w, rect_h, src_w, src_h, angle_deg, flip_out
    output logic [103:0]                       m_tdata,
    input  logic                               cfg_we,
    input  logic [ssrt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssrt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ssrt_pkg::*;

    cfg_t                  cfg_reg;
    logic                  pipe_en;
    logic [PIPE_LAT-1:0]   vld_reg;
    logic                  m_tvalid_reg;
    logic [103:0]          m_tdata_reg;
    side_t                 side_reg [PIPE_LAT];
    geom_t                 geom_reg [SIN_LAT+1];
    logic [SIZE_W-1:0]     szw_reg  [ROT_LAT];
    logic [SIZE_W-1:0]     szh_reg  [ROT_LAT];
    logic signed [15:0]    pa_reg;

    geom_t                 geom_next;
    side_t                 side_next;
    logic signed [17:0]    asum;
    logic signed [23:0]    dprod;

    logic signed [31:0]    sin_q, cos_q;
    logic signed [XW-1:0]  rot_x, rot_y;
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            mneg;
    logic [DIV_W-1:0]      div_x, div_y;
    logic [DIV_STEPS-1:0]  dq   [4];
    logic                  dovf [4];
    logic                  dneg [4];
    side_t                 side_out;

    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_w   <= 14'd640;
            cfg_reg.win_h   <= 14'd480;
            cfg_reg.view_w  <= 16'd640;
            cfg_reg.view_h  <= 16'd480;
            cfg_reg.cam_x   <= 32'sd0;
            cfg_reg.cam_y   <= 32'sd0;
            cfg_reg.cam_ang <= 16'sd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH:  cfg_reg.win_w   <= cfg_wdata[13:0];
                REG_WINDOW_HEIGHT: cfg_reg.win_h   <= cfg_wdata[13:0];
                REG_VIEW_WIDTH:    cfg_reg.view_w  <= cfg_wdata[15:0];
                REG_VIEW_HEIGHT:   cfg_reg.view_h  <= cfg_wdata[15:0];
                REG_CAMERA_X:      cfg_reg.cam_x   <= $signed(cfg_wdata);
                REG_CAMERA_Y:      cfg_reg.cam_y   <= $signed(cfg_wdata);
                REG_CAMERA_ANGLE:  cfg_reg.cam_ang <= $signed(cfg_wdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        geom_next.sw       = SIZE_W'(s_tdata[11:0]) * SIZE_W'(s_tdata[39:24]);
        geom_next.sh       = SIZE_W'(s_tdata[23:12]) * SIZE_W'(s_tdata[55:40]);
        geom_next.parented = s_tuser;
        geom_next.px       = $signed(s_tdata[87:56]);
        geom_next.py       = $signed(s_tdata[119:88]);
        geom_next.parx     = $signed(s_tdata[167:136]);
        geom_next.pary     = $signed(s_tdata[199:168]);

        asum = 18'($signed(s_tdata[135:120]))
               + (s_tuser ? 18'($signed(s_tdata[215:200])) : 18'sd0)
               - 18'(cfg_reg.cam_ang);
        dprod = 24'sd0 - (24'(asum) * 24'sd45);

        side_next.w    = s_tdata[11:0];
        side_next.h    = s_tdata[23:12];
        side_next.deg  = $signed(sat16(dprod >>> 6));
        side_next.flip = s_tdata[217:216];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            vld_reg      <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            geom_reg[0] <= geom_next;
            side_reg[0] <= side_next;
            pa_reg      <= $signed(s_tdata[215:200]);
            for (int k = 1; k <= SIN_LAT; k++) begin
                geom_reg[k] <= geom_reg[k-1];
            end
            for (int k = 1; k < PIPE_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            szw_reg[0] <= geom_reg[SIN_LAT].sw;
            szh_reg[0] <= geom_reg[SIN_LAT].sh;
            for (int k = 1; k < ROT_LAT; k++) begin
                szw_reg[k] <= szw_reg[k-1];
                szh_reg[k] <= szh_reg[k-1];
            end
        end
    end

    ssrt_sine u_sine (
        .aclk  (aclk),
        .en    (pipe_en),
        .angle (pa_reg),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    ssrt_rot u_rot (
        .aclk  (aclk),
        .en    (pipe_en),
        .sin_q (sin_q),
        .cos_q (cos_q),
        .geom  (geom_reg[SIN_LAT]),
        .x     (rot_x),
        .y     (rot_y)
    );

    ssrt_proj u_proj (
        .aclk (aclk),
        .en   (pipe_en),
        .cfg  (cfg_reg),
        .x    (rot_x),
        .y    (rot_y),
        .sw   (szw_reg[ROT_LAT-1]),
        .sh   (szh_reg[ROT_LAT-1]),
        .mag  (mag),
        .neg  (mneg)
    );

    assign div_x = {view_eff(cfg_reg.view_w), 9'd0};
    assign div_y = {view_eff(cfg_reg.view_h), 9'd0};

    for (genvar l = 0; l < 4; l++) begin : g_div
        ssrt_div u_div (
            .aclk    (aclk),
            .en      (pipe_en),
            .mag     (mag[l]),
            .neg     (mneg[l]),
            .d       ((l % 2 == 0) ? div_x : div_y),
            .q       (dq[l]),
            .ovf     (dovf[l]),
            .neg_out (dneg[l])
        );
    end

    assign side_out = side_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_tdata_reg <= {side_out.flip, side_out.deg, side_out.h, side_out.w,
                            sat_q_size(dq[3], dovf[3]),
                            sat_q_size(dq[2], dovf[2]),
                            sat_q_signed(dq[1], dovf[1], dneg[1]),
                            sat_q_signed(dq[0], dovf[0], dneg[0])};
        end
    end

    `SSRT_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0],
        "accepted word did not enter the pipeline")
    `SSRT_ASSERT_NEXT(a_stall_freezes, !pipe_en, $stable(vld_reg) && m_tvalid,
        "pipeline moved during a stall")
    `SSRT_ASSERT_NOW(a_zero_window_w, m_tvalid && (cfg_reg.win_w == 14'd0),
        m_tdata[46:32] == 15'd0, "nonzero width for a zero window width")

endmodule

>>> test/testbench.sv
// Testbench for the sprite world-to-window rectangle transform
`timescale 1ns / 1ps
module testbench;
    import ssrt_pkg::*;

    typedef struct {
        logic [11:0]        w;
        logic [11:0]        h;
        logic [15:0]        scx;
        logic [15:0]        scy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] ang;
        logic               parented;
        logic signed [31:0] parx;
        logic signed [31:0] pary;
        logic signed [15:0] pang;
        logic [1:0]         flip;
    } sprite_t;

    typedef struct packed {
        logic [1:0]  flip;
        logic [15:0] deg;
        logic [11:0] src_h;
        logic [11:0] src_w;
        logic [14:0] rh;
        logic [14:0] rw;
        logic [15:0] ry;
        logic [15:0] rx;
    } rect_t;

    localparam int DRAIN_CYCLES = PIPE_LAT + 8;
    localparam int STALL_LIMIT  = 5000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow registers
    logic [13:0]        sh_win_w;
    logic [13:0]        sh_win_h;
    logic [15:0]        sh_view_w;
    logic [15:0]        sh_view_h;
    logic signed [31:0] sh_cam_x;
    logic signed [31:0] sh_cam_y;
    logic signed [15:0] sh_cam_ang;

    rect_t  pending_rects[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     stall_pct = 20;
    int     hold_left = 0;
    bit     hold_req = 0;

    sprite_screen_rect_transform dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic longint quarter_sin(longint unsigned u14);
        longint unsigned u, u2, t;
        u  = u14 << 16;
        u2 = (u * u) >> 30;
        t  = 64'd172272;
        t  = 64'd5026995 - ((t * u2) >> 30);
        t  = 64'd85569306 - ((t * u2) >> 30);
        t  = 64'd693598669 - ((t * u2) >> 30);
        t  = 64'd1686629713 - ((t * u2) >> 30);
        t  = (t * u) >> 30;
        if (t > 64'd1073741824) t = 64'd1073741824;
        return longint'(t);
    endfunction

    function automatic longint turn_sin(longint unsigned q);
        longint unsigned quad, r;
        longint v;
        quad = (q >> 14) & 3;
        r    = q & 64'h3FFF;
        v    = quad[0] ? quarter_sin(16384 - r) : quarter_sin(r);
        return quad[1] ? -v : v;
    endfunction

    function automatic longint proj_edge(longint num2, logic [15:0] view, logic [13:0] win);
        longint v, n, r;
        v = (view == 0) ? 1 : longint'(view);
        n = (num2 + 256 * v) * longint'(win);
        r = n / (512 * v);
        return r < -32768 ? -32768 : (r > 32767 ? 32767 : r);
    endfunction

    function automatic longint proj_size(longint size, logic [15:0] view, logic [13:0] win);
        longint v, r;
        v = (view == 0) ? 1 : longint'(view);
        r = size * longint'(win) / (256 * v);
        return r > 32767 ? 32767 : r;
    endfunction

    function automatic rect_t screen_rect(sprite_t sp);
        rect_t  r;
        longint sw, sh, x, y, asum, q, s, c, d;
        sw = longint'(sp.w) * longint'(sp.scx);
        sh = longint'(sp.h) * longint'(sp.scy);
        if (sp.parented) begin
            q = ((longint'(sp.pang[12:0]) << 3) >> 6) << 6;
            s = turn_sin(q);
            c = turn_sin((q + 16384) & 64'hFFFF);
            x = longint'(sp.parx) + ((longint'(sp.px) * c - longint'(sp.py) * s) >>> 30);
            y = longint'(sp.pary) + ((longint'(sp.px) * s + longint'(sp.py) * c) >>> 30);
            asum = longint'(sp.ang) + longint'(sp.pang) - longint'(sh_cam_ang);
        end else begin
            x = longint'(sp.px);
            y = longint'(sp.py);
            asum = longint'(sp.ang) - longint'(sh_cam_ang);
        end
        r.rx = 16'(proj_edge(2 * (x - longint'(sh_cam_x)) - sw, sh_view_w, sh_win_w));
        r.ry = 16'(proj_edge(2 * (longint'(sh_cam_y) - y) - sh, sh_view_h, sh_win_h));
        r.rw = 15'(proj_size(sw, sh_view_w, sh_win_w));
        r.rh = 15'(proj_size(sh, sh_view_h, sh_win_h));
        r.src_w = sp.w;
        r.src_h = sp.h;
        d = (-asum * 45) >>> 6;
        r.deg = 16'(d < -32768 ? -32768 : (d > 32767 ? 32767 : d));
        r.flip = sp.flip;
        return r;
    endfunction

    function automatic logic [31:0] pick32(int moderate);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 2 * moderate))) - 32'(moderate);
        endcase
    endfunction

    function automatic sprite_t rand_sprite();
        sprite_t sp;
        sp.w    = $urandom_range(0, 3) == 0 ? 12'($urandom()) : 12'($urandom_range(0, 128));
        sp.h    = $urandom_range(0, 3) == 0 ? 12'($urandom()) : 12'($urandom_range(0, 128));
        sp.scx  = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 1024));
        sp.scy  = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 1024));
        sp.px   = pick32(300000);
        sp.py   = pick32(300000);
        sp.ang  = 16'($urandom());
        sp.parented = 1'($urandom_range(0, 1));
        sp.parx = pick32(300000);
        sp.pary = pick32(300000);
        sp.pang = 16'($urandom());
        sp.flip = 2'($urandom());
        return sp;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        while (pending_rects.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_WINDOW_WIDTH:  sh_win_w   = val[13:0];
            REG_WINDOW_HEIGHT: sh_win_h   = val[13:0];
            REG_VIEW_WIDTH:    sh_view_w  = val[15:0];
            REG_VIEW_HEIGHT:   sh_view_h  = val[15:0];
            REG_CAMERA_X:      sh_cam_x   = val;
            REG_CAMERA_Y:      sh_cam_y   = val;
            REG_CAMERA_ANGLE:  sh_cam_ang = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_camera(logic [13:0] ww, logic [13:0] wh, logic [15:0] vw,
                              logic [15:0] vh, logic [31:0] cx, logic [31:0] cy,
                              logic [15:0] ca);
        write_reg(REG_WINDOW_WIDTH, 32'(ww));
        write_reg(REG_WINDOW_HEIGHT, 32'(wh));
        write_reg(REG_VIEW_WIDTH, 32'(vw));
        write_reg(REG_VIEW_HEIGHT, 32'(vh));
        write_reg(REG_CAMERA_X, cx);
        write_reg(REG_CAMERA_Y, cy);
        write_reg(REG_CAMERA_ANGLE, 32'(ca));
    endtask

    task automatic send_sprite(sprite_t sp, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sp.parented;
        s_tdata  <= {6'd0, sp.flip, sp.pang, sp.pary, sp.parx, sp.ang, sp.py, sp.px,
                     sp.scy, sp.scx, sp.h, sp.w};
        do @(negedge aclk); while (!s_tready);
        pending_rects.insert(pending_rects.size(), screen_rect(sp));
        @(posedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic test_directed();
        sprite_t sp;
        int      i;
        for (i = 0; i < 24; i++) begin
            sp = rand_sprite();
            sp.parented = i[0];
            case (i % 8)
                0: begin
                    sp.w = 12'hFFF; sp.h = 12'hFFF; sp.scx = 16'hFFFF; sp.scy = 16'hFFFF;
                end
                1: begin
                    sp.w = 12'd0; sp.h = 12'd0; sp.scx = 16'd0; sp.scy = 16'd0;
                    sp.px = 32'sd0; sp.py = 32'sd0;
                end
                2: begin
                    sp.px = 32'h7FFF_FFFF; sp.py = 32'h8000_0000;
                    sp.parx = 32'h7FFF_FFFF; sp.pary = 32'h8000_0000;
                end
                3: begin
                    sp.px = 32'h8000_0000; sp.py = 32'h7FFF_FFFF;
                    sp.parx = 32'h8000_0000; sp.pary = 32'h7FFF_FFFF;
                end
                4: begin
                    sp.ang = 16'h7FFF; sp.pang = 16'h7FFF;
                end
                5: begin
                    sp.ang = 16'h8000; sp.pang = 16'h8000;
                end
                6: begin
                    sp.pang = 16'(i * 1024); sp.px = 32'd25600; sp.py = -32'sd12800;
                end
                default: begin
                    sp.w = 12'd64; sp.h = 12'd32; sp.scx = 16'h0100; sp.scy = 16'h0200;
                    sp.pang = 16'h1000;
                end
            endcase
            sp.flip = 2'(i);
            send_sprite(sp, i % 3);
        end
        stop_sending();
    endtask

    task automatic test_random_phase(int count);
        int i;
        for (i = 0; i < count; i++) send_sprite(rand_sprite(), rand_gap());
        stop_sending();
    endtask

    task automatic test_config_extremes();
        set_camera(14'd1, 14'd1, 16'd65535, 16'd65535, 32'h7FFF_FFFF, 32'h8000_0000,
                   16'h7FFF);
        test_random_phase(60);
        // zero viewport and zero window width
        set_camera(14'd0, 14'd16383, 16'd0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
        test_random_phase(60);
        set_camera(14'd8192, 14'd0, 16'd1, 16'd1, 32'd0, 32'd0, 16'd0);
        test_random_phase(60);
    endtask

    task automatic test_random_configs();
        int k;
        for (k = 0; k < 5; k++) begin
            set_camera(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                       16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                       pick32(500000), pick32(500000), 16'($urandom()));
            stall_pct = (k == 2) ? 0 : 10 * k;
            test_random_phase(240);
        end
        stall_pct = 20;
    endtask

    task automatic test_backpressure();
        int i;
        hold_req = 1;
        for (i = 0; i < 80; i++) send_sprite(rand_sprite(), 0);
        stop_sending();
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 20; i++) send_sprite(rand_sprite(), rand_gap());
        stop_sending();
        while (pending_rects.size() > 0) @(posedge aclk);
        for (i = 0; i < 20; i++) send_sprite(rand_sprite(), 0);
        stop_sending();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_left = 400;
                hold_req = 0;
            end else if (hold_left == 0 && $urandom_range(0, 199) == 0) begin
                hold_left = $urandom_range(15, 60);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(negedge aclk) begin
        rect_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_rects.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_tdata);
            end else begin
                want = pending_rects.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch rx %0d/%0d ry %0d/%0d rw %0d/%0d rh %0d/%0d",
                                 $signed(want.rx), $signed(got.rx), $signed(want.ry),
                                 $signed(got.ry), want.rw, got.rw, want.rh, got.rh);
                        $display("  src %0d,%0d/%0d,%0d deg %0d/%0d flip %0d/%0d",
                                 want.src_w, want.src_h, got.src_w, got.src_h,
                                 $signed(want.deg), $signed(got.deg), want.flip, got.flip);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        sh_win_w = 14'd640; sh_win_h = 14'd480; sh_view_w = 16'd640; sh_view_h = 16'd480;
        sh_cam_x = 32'sd0; sh_cam_y = 32'sd0; sh_cam_ang = 16'sd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_config_extremes();
        test_random_configs();
        test_drain_pause();
        while (pending_rects.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
